/* hdl/ahc_pkg.sv */
// shared types, codes and helper functions for the advertising record classifier
package ahc_pkg;

    typedef enum logic [1:0] {
        PH_LENGTH = 2'd0,
        PH_TYPE   = 2'd1,
        PH_VALUE  = 2'd2
    } t_phase;

    typedef enum logic [1:0] {
        KIND_OTHER  = 2'd0,
        KIND_UUID16 = 2'd1,
        KIND_APPEAR = 2'd2
    } t_kind;

    typedef enum logic [2:0] {
        CLS_NONE        = 3'd0,
        CLS_GENERIC     = 3'd1,
        CLS_KEYBOARD    = 3'd2,
        CLS_MOUSE       = 3'd3,
        CLS_UNSUPPORTED = 3'd4,
        CLS_CONFLICT    = 3'd5
    } t_cls;

    localparam logic [7:0]  AD_UUID16_INC = 8'h02;
    localparam logic [7:0]  AD_UUID16_CMP = 8'h03;
    localparam logic [7:0]  AD_APPEAR     = 8'h19;
    localparam logic [7:0]  APPEAR_LEN    = 8'd3;
    localparam logic [15:0] UUID_HID      = 16'h1812;
    localparam logic [15:0] APP_GENERIC   = 16'h03c0;
    localparam logic [15:0] APP_KEYBOARD  = 16'h03c1;
    localparam logic [15:0] APP_MOUSE     = 16'h03c2;
    localparam logic [15:0] APP_HID_MASK  = 16'hffc0;

    typedef struct packed {
        t_phase     phase;
        logic [7:0] bytes_left;
        t_kind      kind;
        logic [7:0] low_half;
        logic       half_select;
        logic       item_hid;
        t_cls       item_class;
        logic       com_hid;
        t_cls       com_class;
        logic       err;
        logic       term;
    } t_state;

    typedef struct packed {
        logic       record_ok;
        logic       hid_found;
        logic [2:0] appearance_class;
    } t_result;

    localparam t_state STATE_RESET = '{
        phase:       PH_LENGTH,
        bytes_left:  8'd0,
        kind:        KIND_OTHER,
        low_half:    8'd0,
        half_select: 1'b0,
        item_hid:    1'b0,
        item_class:  CLS_NONE,
        com_hid:     1'b0,
        com_class:   CLS_NONE,
        err:         1'b0,
        term:        1'b0
    };

    function automatic t_cls sort_appearance(input logic [15:0] a);
        t_cls c;
        if (a == APP_GENERIC) c = CLS_GENERIC;
        else if (a == APP_KEYBOARD) c = CLS_KEYBOARD;
        else if (a == APP_MOUSE) c = CLS_MOUSE;
        else if ((a & APP_HID_MASK) == APP_GENERIC) c = CLS_UNSUPPORTED;
        else c = CLS_NONE;
        return c;
    endfunction

    function automatic t_cls join_class(input t_cls cur, input t_cls seen);
        t_cls c;
        if (seen == CLS_NONE) c = cur;
        else if (cur == CLS_NONE || cur == seen) c = seen;
        else c = CLS_CONFLICT;
        return c;
    endfunction

endpackage

/* hdl/ahc_if.sv */
// valid/ready channel interfaces for record bytes and classification results
interface ahc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;
    logic       empty_record;

    modport source (output valid, output data_byte, output last_byte,
                    output empty_record, input ready);
    modport sink   (input valid, input data_byte, input last_byte,
                    input empty_record, output ready);
endinterface

interface ahc_out_if;
    logic       valid;
    logic       ready;
    logic       record_ok;
    logic       hid_found;
    logic [2:0] appearance_class;

    modport source (output valid, output record_ok, output hid_found,
                    output appearance_class, input ready);
    modport sink   (input valid, input record_ok, input hid_found,
                    input appearance_class, output ready);
endinterface

/* hdl/ahc_step.sv */
// per-byte parser update: next state and end-of-record result
module ahc_step
    import ahc_pkg::*;
(
    input  t_state     i_state,
    input  logic [7:0] i_data_byte,
    input  logic       i_last_byte,
    input  logic       i_empty_record,
    output t_state     o_state,
    output logic       o_emit,
    output t_result    o_result
);

    t_state     s;
    logic [7:0] vlen;
    logic [15:0] word;
    t_cls       cls;

    assign vlen = 8'(i_state.bytes_left - 8'd1);
    assign word = {i_data_byte, i_state.low_half};
    assign cls  = sort_appearance(word);

    always_comb begin
        s = i_state;
        if (!i_state.err) begin
            if (i_state.term) begin
                // any byte after a terminator
                s.err = 1'b1;
            end else if (i_state.phase == PH_LENGTH) begin
                if (i_data_byte == 8'd0) begin
                    s.term = 1'b1;
                end else begin
                    s.bytes_left = i_data_byte;
                    s.phase      = PH_TYPE;
                end
            end else if (i_state.phase == PH_TYPE) begin
                s.kind        = KIND_OTHER;
                s.low_half    = 8'd0;
                s.half_select = 1'b0;
                s.item_hid    = 1'b0;
                s.item_class  = CLS_NONE;
                if (i_data_byte == AD_UUID16_INC || i_data_byte == AD_UUID16_CMP) begin
                    s.kind = KIND_UUID16;
                    if (vlen[0]) s.err = 1'b1;
                end else if (i_data_byte == AD_APPEAR) begin
                    s.kind = KIND_APPEAR;
                    if (i_state.bytes_left != APPEAR_LEN) s.err = 1'b1;
                end
                if (!s.err) begin
                    s.bytes_left = vlen;
                    if (vlen == 8'd0) begin
                        // type-only structure completes here
                        s.phase = PH_LENGTH;
                        s.kind  = KIND_OTHER;
                    end else begin
                        s.phase = PH_VALUE;
                    end
                end
            end else begin
                if (!i_state.half_select) begin
                    s.low_half    = i_data_byte;
                    s.half_select = 1'b1;
                end else begin
                    s.half_select = 1'b0;
                    if (i_state.kind == KIND_UUID16) begin
                        if (word == UUID_HID) s.item_hid = 1'b1;
                    end else if (i_state.kind == KIND_APPEAR) begin
                        s.item_class = cls;
                        if (cls != CLS_NONE) s.item_hid = 1'b1;
                    end
                end
                s.bytes_left = vlen;
                if (vlen == 8'd0) begin
                    // commit the finished structure
                    if (s.item_hid) s.com_hid = 1'b1;
                    if (s.kind == KIND_APPEAR) s.com_class = join_class(s.com_class, s.item_class);
                    s.kind        = KIND_OTHER;
                    s.low_half    = 8'd0;
                    s.half_select = 1'b0;
                    s.item_hid    = 1'b0;
                    s.item_class  = CLS_NONE;
                    s.phase       = PH_LENGTH;
                end
            end
        end

        o_emit   = i_empty_record || i_last_byte;
        o_result = '{record_ok: 1'b1, hid_found: 1'b0, appearance_class: 3'd0};
        o_state  = s;
        if (i_empty_record) begin
            o_state = STATE_RESET;
        end else if (i_last_byte) begin
            // a structure still open at the end is truncated
            o_result.record_ok        = !(s.err || s.phase != PH_LENGTH);
            o_result.hid_found        = s.com_hid;
            o_result.appearance_class = s.com_class;
            o_state                   = STATE_RESET;
        end
    end

endmodule

/* hdl/adv_record_hid_classifier.sv */
// a result is registered in the result register once its last byte has passed the input register
// throughput: one byte per cycle; the input register and the result register
// decouple the two channels, so bytes keep flowing while a result waits
// a stalled result only holds back a following byte that ends another record
// reset: synchronous active-low i_rst_n clears both valids and the parser state
module adv_record_hid_classifier
    import ahc_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    ahc_in_if.sink    i_in,
    ahc_out_if.source o_res
);

    logic       r_in_valid;
    logic [7:0] r_data_byte;
    logic       r_last_byte;
    logic       r_empty_record;
    t_state     r_state;
    t_state     n_state;
    logic       r_out_valid;
    t_result    r_result;
    t_result    n_result;
    logic       emit;
    logic       step_go;

    ahc_step u_step (
        .i_state        (r_state),
        .i_data_byte    (r_data_byte),
        .i_last_byte    (r_last_byte),
        .i_empty_record (r_empty_record),
        .o_state        (n_state),
        .o_emit         (emit),
        .o_result       (n_result)
    );

    assign step_go    = r_in_valid && (!emit || !r_out_valid || o_res.ready);
    assign i_in.ready = !r_in_valid || step_go;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= STATE_RESET;
        end else begin
            if (i_in.ready) r_in_valid <= i_in.valid;
            if (step_go) r_state <= n_state;
            if (step_go && emit) r_out_valid <= 1'b1;
            else if (o_res.ready) r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_data_byte    <= i_in.data_byte;
            r_last_byte    <= i_in.last_byte;
            r_empty_record <= i_in.empty_record;
        end
        if (step_go && emit) r_result <= n_result;
    end

    assign o_res.valid            = r_out_valid;
    assign o_res.record_ok        = r_result.record_ok;
    assign o_res.hid_found        = r_result.hid_found;
    assign o_res.appearance_class = r_result.appearance_class;

endmodule

/* hdl/ahc_checker.sv */
// port-level assertions for the classifier and their bind to the top level
module ahc_checker
    import ahc_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic       i_record_ok,
    input logic       i_hid_found,
    input logic [2:0] i_appearance_class
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result dropped while stalled");

    a_class_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_appearance_class <= CLS_CONFLICT)
        else $error("appearance class out of range");

    // a committed class always came with a hid mark
    a_class_hid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_hid_found |-> i_appearance_class == CLS_NONE)
        else $error("class reported without hid");

    a_reset_idle: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !i_out_valid)
        else $error("result valid right after reset");

    a_ok_known: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> !$isunknown({i_record_ok, i_hid_found}))
        else $error("unknown result flags");

endmodule

bind adv_record_hid_classifier ahc_checker u_ahc_checker (
    .i_clk              (i_clk),
    .i_rst_n            (i_rst_n),
    .i_out_valid        (o_res.valid),
    .i_out_ready        (o_res.ready),
    .i_record_ok        (o_res.record_ok),
    .i_hid_found        (o_res.hid_found),
    .i_appearance_class (o_res.appearance_class)
);
